// ===== sv/ctc_pkg.sv =====
package ctc_pkg;

  localparam int NUM_ELEMENTS  = 17;
  localparam int NUM_TEMPLATES = 6;

  localparam int X_W      = 16;
  localparam int W_W      = 4;
  localparam int POS_W    = 5;
  localparam int TIDX_W   = 3;
  localparam int DOT_W    = 24;
  localparam int SQ_W     = 35;
  localparam int TSQ_W    = 11;
  localparam int PROD_W   = 46;
  localparam int DEN_W    = 24;
  localparam int REM_W    = 40;
  localparam int FRAC_W   = 16;
  localparam int Q_W      = 17;
  localparam int SCORE_W  = 18;
  localparam int CNT_W    = 5;
  localparam int SQRT_STEPS = PROD_W / 2;
  localparam int DIV_STEPS  = Q_W;

  localparam logic [2:0]  NEUTRAL_CODE  = 3'd6;
  localparam logic [15:0] MIN_SIM_RESET = 16'd19661;
  localparam logic signed [SCORE_W-1:0] BEST_INIT = -18'sd65536;

  localparam logic [W_W-1:0] TMPL_W [NUM_TEMPLATES][NUM_ELEMENTS] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd8, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd8, 4'd0, 4'd0, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd8, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd9, 4'd7, 4'd0, 4'd8, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd7},
    '{4'd8, 4'd7, 4'd0, 4'd6, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd8,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd7, 4'd6, 4'd0},
    '{4'd8, 4'd8, 4'd0, 4'd0, 4'd7, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  typedef enum logic [2:0] {
    ST_ACC,
    ST_START,
    ST_WAIT,
    ST_FIN
  } ctl_state_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL,
    SC_SQRT,
    SC_DIV,
    SC_DONE
  } sc_state_e;

  typedef struct packed {
    logic acc_en;
    logic shift_en;
  } cell_ctl_t;

  function automatic logic [W_W-1:0] weight_of(input logic [TIDX_W-1:0] t,
                                                input logic [POS_W-1:0] pos);
    logic [W_W-1:0] w;
    w = '0;
    if (int'(pos) < NUM_ELEMENTS && int'(t) < NUM_TEMPLATES) begin
      w = TMPL_W[t][pos];
    end
    return w;
  endfunction

  function automatic logic [TSQ_W-1:0] tsq_of(input logic [TIDX_W-1:0] t);
    logic [TSQ_W-1:0] acc;
    acc = '0;
    if (int'(t) < NUM_TEMPLATES) begin
      for (int k = 0; k < NUM_ELEMENTS; k++) begin
        acc = acc + TSQ_W'(TMPL_W[t][k]) * TSQ_W'(TMPL_W[t][k]);
      end
    end
    return acc;
  endfunction

endpackage

// ===== sv/ctc_cell.sv =====
module ctc_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ctc_pkg::cell_ctl_t                    ctl_i,
  input  logic signed [ctc_pkg::X_W-1:0]        x_i,
  input  logic [ctc_pkg::W_W-1:0]               weight_i,
  input  logic signed [ctc_pkg::DOT_W-1:0]      dot_i,
  output logic signed [ctc_pkg::DOT_W-1:0]      dot_o
);

  logic signed [ctc_pkg::DOT_W-1:0] acc_q, acc_d;
  logic signed [ctc_pkg::X_W+ctc_pkg::W_W:0] prod;

  assign prod = x_i * $signed({1'b0, weight_i});

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.shift_en) begin
      acc_d = dot_i;
    end else if (ctl_i.acc_en) begin
      acc_d = acc_q + ctc_pkg::DOT_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign dot_o = acc_q;

endmodule

// ===== sv/ctc_score.sv =====
module ctc_score (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [ctc_pkg::DOT_W-1:0]      dot_i,
  input  logic [ctc_pkg::SQ_W-1:0]              sq_i,
  input  logic [ctc_pkg::TSQ_W-1:0]             tsq_i,
  output logic                                  done_o,
  output logic signed [ctc_pkg::SCORE_W-1:0]    score_o
);

  ctc_pkg::sc_state_e state_q, state_d;

  logic [ctc_pkg::CNT_W-1:0]  cnt_q;
  logic [ctc_pkg::DOT_W-1:0]  dabs_q;
  logic                       neg_q;
  logic                       zero_q;
  logic [ctc_pkg::SQ_W-1:0]   sq_q;
  logic [ctc_pkg::TSQ_W-1:0]  tsq_q;
  logic [ctc_pkg::PROD_W-1:0] v_q, res_q, bit_q;
  logic [ctc_pkg::REM_W-1:0]  rem_q, dsh_q;
  logic [ctc_pkg::Q_W-1:0]    quo_q;

  logic [ctc_pkg::PROD_W-1:0] trial, v_nx, res_nx;
  logic                       sqrt_last, div_last;
  logic signed [ctc_pkg::SCORE_W-1:0] mag;

  always_comb begin
    trial = res_q + bit_q;
    if (v_q >= trial) begin
      v_nx   = v_q - trial;
      res_nx = (res_q >> 1) + bit_q;
    end else begin
      v_nx   = v_q;
      res_nx = res_q >> 1;
    end
  end

  assign sqrt_last = (cnt_q == ctc_pkg::CNT_W'(ctc_pkg::SQRT_STEPS - 1));
  assign div_last  = (cnt_q == ctc_pkg::CNT_W'(ctc_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctc_pkg::SC_IDLE: if (start_i) state_d = ctc_pkg::SC_MUL;
      ctc_pkg::SC_MUL: begin
        if (sq_q == '0 || tsq_q == '0) begin
          state_d = ctc_pkg::SC_DONE;
        end else begin
          state_d = ctc_pkg::SC_SQRT;
        end
      end
      ctc_pkg::SC_SQRT: if (sqrt_last) state_d = ctc_pkg::SC_DIV;
      ctc_pkg::SC_DIV:  if (div_last) state_d = ctc_pkg::SC_DONE;
      ctc_pkg::SC_DONE: state_d = ctc_pkg::SC_IDLE;
      default:          state_d = ctc_pkg::SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctc_pkg::SC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ctc_pkg::SC_IDLE: begin
        neg_q  <= dot_i[ctc_pkg::DOT_W-1];
        dabs_q <= dot_i[ctc_pkg::DOT_W-1] ? ctc_pkg::DOT_W'(-dot_i)
                                          : ctc_pkg::DOT_W'(dot_i);
        sq_q   <= sq_i;
        tsq_q  <= tsq_i;
      end
      ctc_pkg::SC_MUL: begin
        zero_q <= (sq_q == '0 || tsq_q == '0);
        v_q    <= ctc_pkg::PROD_W'(sq_q) * ctc_pkg::PROD_W'(tsq_q);
        res_q  <= '0;
        bit_q  <= ctc_pkg::PROD_W'(1) << (ctc_pkg::PROD_W - 2);
        cnt_q  <= '0;
        quo_q  <= '0;
      end
      ctc_pkg::SC_SQRT: begin
        v_q   <= v_nx;
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        if (sqrt_last) begin
          cnt_q <= '0;
          rem_q <= {ctc_pkg::REM_W'(dabs_q)} << ctc_pkg::FRAC_W;
          dsh_q <= ctc_pkg::REM_W'(res_nx[ctc_pkg::DEN_W-1:0]) << ctc_pkg::FRAC_W;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      ctc_pkg::SC_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[ctc_pkg::Q_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[ctc_pkg::Q_W-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q + 1'b1;
      end
      ctc_pkg::SC_DONE: ;
      default: ;
    endcase
  end

  assign mag = $signed({1'b0, quo_q});

  always_comb begin
    done_o  = (state_q == ctc_pkg::SC_DONE);
    score_o = '0;
    if (!zero_q) begin
      score_o = neg_q ? -mag : mag;
    end
  end

endmodule

// ===== sv/cosine_template_classifier.sv =====
// Each feature word is taken while the input is not stalled, so a 17-word vector streams in word by word.
// After the last word the six templates are scored in turn by a shared multiply,
// 23-step square root and 17-step restoring divider; the square root and divide
// steps are skipped for a template when a norm is zero.
// Input is stalled during scoring, so one vector is in flight at a time.
// Reset clears the state machines and accumulators and sets the threshold to 19661.
module cosine_template_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] feature_value_i,
  input  logic        feature_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  class_code_o,
  output logic [15:0] confidence_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int NT = ctc_pkg::NUM_TEMPLATES;

  ctc_pkg::ctl_state_e state_q, state_d;

  logic [15:0]                       min_sim_q;
  logic [ctc_pkg::POS_W-1:0]         pos_q;
  logic [ctc_pkg::SQ_W-1:0]          sq_q;
  logic [ctc_pkg::TIDX_W-1:0]        tidx_q;
  logic signed [ctc_pkg::SCORE_W-1:0] best_q;
  logic [2:0]                        cls_q;
  logic                              out_valid_q;
  logic [2:0]                        class_q;
  logic [15:0]                       conf_q;

  logic                              in_acc, take, last_t, sc_start, fin_load;
  ctc_pkg::cell_ctl_t                cell_ctl;
  logic signed [ctc_pkg::X_W-1:0]    x;
  logic signed [2*ctc_pkg::X_W-1:0]  xsq;
  logic signed [ctc_pkg::DOT_W-1:0]  dot [NT];
  logic                              sc_done;
  logic signed [ctc_pkg::SCORE_W-1:0] score;
  logic [15:0]                       conf_nx;

  assign x      = $signed(feature_value_i);
  assign xsq    = x * x;
  assign in_acc = in_valid_i && !in_stall_o;
  assign take   = in_acc && (int'(pos_q) < ctc_pkg::NUM_ELEMENTS);
  assign last_t = (tidx_q == ctc_pkg::TIDX_W'(NT - 1));

  for (genvar i = 0; i < NT; i++) begin : g_cell
    logic signed [ctc_pkg::DOT_W-1:0] dot_in;
    if (i == NT - 1) begin : g_tail
      assign dot_in = '0;
    end else begin : g_link
      assign dot_in = dot[i+1];
    end
    ctc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (cell_ctl),
      .x_i      (x),
      .weight_i (ctc_pkg::weight_of(ctc_pkg::TIDX_W'(i), pos_q)),
      .dot_i    (dot_in),
      .dot_o    (dot[i])
    );
  end

  ctc_score u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .dot_i   (dot[0]),
    .sq_i    (sq_q),
    .tsq_i   (ctc_pkg::tsq_of(tidx_q)),
    .done_o  (sc_done),
    .score_o (score)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctc_pkg::ST_ACC:   if (in_acc && feature_last_i) state_d = ctc_pkg::ST_START;
      ctc_pkg::ST_START: state_d = ctc_pkg::ST_WAIT;
      ctc_pkg::ST_WAIT: begin
        if (sc_done) begin
          state_d = last_t ? ctc_pkg::ST_FIN : ctc_pkg::ST_START;
        end
      end
      ctc_pkg::ST_FIN:   if (!out_valid_q || !out_stall_i) state_d = ctc_pkg::ST_ACC;
      default:           state_d = ctc_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != ctc_pkg::ST_ACC);
    sc_start          = (state_q == ctc_pkg::ST_START);
    fin_load          = (state_q == ctc_pkg::ST_FIN) && (!out_valid_q || !out_stall_i);
    cell_ctl.acc_en   = take;
    cell_ctl.shift_en = (state_q == ctc_pkg::ST_WAIT) && sc_done;
  end

  always_comb begin
    conf_nx = '0;
    if (best_q > 0) begin
      conf_nx = (best_q > $signed(18'sd65535)) ? 16'hFFFF : best_q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctc_pkg::ST_ACC;
      min_sim_q   <= ctc_pkg::MIN_SIM_RESET;
      pos_q       <= '0;
      sq_q        <= '0;
      tidx_q      <= '0;
      best_q      <= ctc_pkg::BEST_INIT;
      cls_q       <= ctc_pkg::NEUTRAL_CODE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        min_sim_q <= cfg_wdata_i;
      end
      if (take) begin
        pos_q <= pos_q + 1'b1;
        sq_q  <= sq_q + ctc_pkg::SQ_W'($unsigned(xsq));
      end
      if (cell_ctl.shift_en) begin
        tidx_q <= tidx_q + 1'b1;
        if (score > best_q) begin
          best_q <= score;
          cls_q  <= 3'(tidx_q);
        end
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
        pos_q       <= '0;
        sq_q        <= '0;
        tidx_q      <= '0;
        best_q      <= ctc_pkg::BEST_INIT;
        cls_q       <= ctc_pkg::NEUTRAL_CODE;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      conf_q  <= conf_nx;
      class_q <= (best_q < $signed({2'b00, min_sim_q})) ? ctc_pkg::NEUTRAL_CODE : cls_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign class_code_o = class_q;
  assign confidence_o = conf_q;

endmodule
